// ----- rtl/dti_pkg.sv -----
// Shared constants, codes and types of the decision tree inference block.
`default_nettype none

package dti_pkg;

	localparam int unsigned MAX_NODES    = 64;
	localparam int unsigned NUM_FEATURES = 7;
	localparam int unsigned DEPTH_LIMIT  = 8;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned FEAT_W = 3;
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned LVL_W  = $clog2(DEPTH_LIMIT + 1);

	// The node and feature limits are widened by one bit so that the compares stay exact.
	localparam logic [IDX_W:0]  IDX_LIMIT  = (IDX_W + 1)'(MAX_NODES);
	localparam logic [FEAT_W:0] FEAT_LIMIT = (FEAT_W + 1)'(NUM_FEATURES);
	localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(DEPTH_LIMIT - 1);

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_PREDICT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_REJECT      = 3'd1,
		STAT_NO_TREE     = 3'd2,
		STAT_INVALID     = 3'd3,
		STAT_BAD_FEATURE = 3'd4,
		STAT_DEPTH       = 3'd5
	} status_t;

	typedef struct packed {
		logic [FEAT_W-1:0]       feature;
		logic signed [VAL_W-1:0] threshold;
		logic [IDX_W-1:0]        left;
		logic [IDX_W-1:0]        right;
		logic signed [VAL_W-1:0] value;
	} node_t;

	localparam int unsigned NODE_W = $bits(node_t);

endpackage

`default_nettype wire

// ----- rtl/dti_if.sv -----
// Channel interfaces of the decision tree inference block: request, response, configuration.
`default_nettype none

interface dti_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       operation;
	logic [dti_pkg::IDX_W-1:0]        node_index;
	logic [dti_pkg::FEAT_W-1:0]       feature_select;
	logic signed [dti_pkg::VAL_W-1:0] split_threshold;
	logic [dti_pkg::IDX_W-1:0]        left_index;
	logic [dti_pkg::IDX_W-1:0]        right_index;
	logic signed [dti_pkg::VAL_W-1:0] leaf_value;
	logic signed [dti_pkg::VAL_W-1:0] feature_value;

	modport source (output valid, operation, node_index, feature_select, split_threshold,
		left_index, right_index, leaf_value, feature_value, input ready);
	modport sink (input valid, operation, node_index, feature_select, split_threshold,
		left_index, right_index, leaf_value, feature_value, output ready);
endinterface

interface dti_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [dti_pkg::VAL_W-1:0] prediction;
	logic [2:0]                       status;
	logic [dti_pkg::IDX_W-1:0]        nodes_in_use;

	modport source (output valid, prediction, status, nodes_in_use, input ready);
	modport sink (input valid, prediction, status, nodes_in_use, output ready);
endinterface

interface dti_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [dti_pkg::IDX_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/decision_tree_inference.sv -----
// Top level of the decision tree inference block: node table walk and request handling.
//
// Requests arrive as words on req; each one gives exactly one response word on rsp.
// A node write stores one node in the node table, a feature load sets one feature, and
// a predict walks the tree from the root held in the configuration register. The user
// must write it through cfg only while the block is idle; the block does not enforce it.
// A node write or feature load goes from acceptance to the result state and then into the
// response register. A predict reads one node per cycle from the node table RAM and
// visits at most DEPTH_LIMIT nodes before it moves to the result state.
// One request is worked on at a time; req.ready is high while the block is idle. The
// response register frees the request side: the next request is taken while a finished
// response still waits, and a new result waits in turn until the register is free.
// Reset empties the node table (every entry reads as a zero leaf through its valid bit),
// clears the features and the node count, and sets the root to node 1. There is no
// clearing pass. When the receiver stalls, the response word is held until taken.
`default_nettype none

module decision_tree_inference (
	input  wire logic clk,
	input  wire logic arst_n,
	dti_req_if.sink   req,
	dti_rsp_if.source rsp,
	dti_cfg_if.sink   cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESULT
	} state_t;

	state_t state_q;

	logic [dti_pkg::IDX_W-1:0]        root_q;
	logic [dti_pkg::IDX_W-1:0]        node_count_q;
	logic [dti_pkg::MAX_NODES-1:0]    valid_q;
	logic signed [dti_pkg::VAL_W-1:0] feat_q [dti_pkg::NUM_FEATURES];
	logic [dti_pkg::LVL_W-1:0]        level_q;
	logic                             vld_s1;
	logic signed [dti_pkg::VAL_W-1:0] res_pred_q;
	dti_pkg::status_t                 res_status_q;
	logic                             rsp_valid_q;
	logic signed [dti_pkg::VAL_W-1:0] rsp_pred_q;
	dti_pkg::status_t                 rsp_status_q;
	logic [dti_pkg::IDX_W-1:0]        rsp_count_q;

	logic                         accept;
	dti_pkg::op_t                 op;
	logic                         wr_en;
	logic [dti_pkg::NODE_W-1:0]   ram_rdata;
	dti_pkg::node_t               wr_node;
	dti_pkg::node_t               cur_node;
	logic [dti_pkg::IDX_W-1:0]    rd_addr;
	logic                         idx_write_bad;
	logic                         load_bad;
	logic                         root_bad;
	logic                         is_leaf;
	logic                         feat_bad;
	logic signed [dti_pkg::VAL_W-1:0] feat_val;
	logic                         go_left;
	logic [dti_pkg::IDX_W-1:0]    next_idx;
	logic                         next_bad;
	logic                         last_level;
	logic                         out_free;
	logic                         load_rsp;

	assign accept   = req.valid && req.ready;
	assign op       = dti_pkg::op_t'(req.operation);
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign load_rsp = (state_q == S_RESULT) && out_free;

	assign idx_write_bad = (req.node_index == '0) ||
		({1'b0, req.node_index} >= dti_pkg::IDX_LIMIT);
	assign load_bad = ({1'b0, req.feature_select} >= dti_pkg::FEAT_LIMIT);
	assign root_bad = (root_q > node_count_q) ||
		({1'b0, root_q} >= dti_pkg::IDX_LIMIT);

	assign wr_en = accept && (op == dti_pkg::OP_WRITE) && !idx_write_bad;
	always_comb begin
		wr_node.feature   = req.feature_select;
		wr_node.threshold = req.split_threshold;
		wr_node.left      = req.left_index;
		wr_node.right     = req.right_index;
		wr_node.value     = req.leaf_value;
	end

	// An entry never written reads as a zero leaf.
	assign cur_node = vld_s1 ? dti_pkg::node_t'(ram_rdata) : '0;

	assign is_leaf  = (cur_node.left == '0) && (cur_node.right == '0);
	assign feat_bad = ({1'b0, cur_node.feature} >= dti_pkg::FEAT_LIMIT);
	assign feat_val = feat_bad ? '0 : feat_q[cur_node.feature];
	assign go_left  = (feat_val <= cur_node.threshold);
	assign next_idx = go_left ? cur_node.left : cur_node.right;
	assign next_bad = (next_idx == '0) || (next_idx > node_count_q) ||
		({1'b0, next_idx} >= dti_pkg::IDX_LIMIT);
	assign last_level = (level_q == dti_pkg::LAST_LEVEL);

	// The root is read on the accepting edge, every later node straight from the walk.
	assign rd_addr = (state_q == S_IDLE) ? root_q : next_idx;

	dti_ram #(
		.WIDTH (dti_pkg::NODE_W),
		.DEPTH (dti_pkg::MAX_NODES)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.node_index),
		.wr_data (wr_node),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_q       <= dti_pkg::IDX_W'(1);
			node_count_q <= '0;
			valid_q      <= '0;
			for (int i = 0; i < dti_pkg::NUM_FEATURES; i++) begin
				feat_q[i] <= '0;
			end
			level_q      <= '0;
			vld_s1       <= 1'b0;
			res_pred_q   <= '0;
			res_status_q <= dti_pkg::STAT_OK;
			rsp_valid_q  <= 1'b0;
			rsp_pred_q   <= '0;
			rsp_status_q <= dti_pkg::STAT_OK;
			rsp_count_q  <= '0;
		end else begin
			vld_s1 <= valid_q[rd_addr];
			if (cfg.valid && cfg.ready) begin
				root_q <= cfg.data;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_pred_q <= '0;
						level_q    <= '0;
						unique case (op)
							dti_pkg::OP_WRITE: begin
								state_q <= S_RESULT;
								if (idx_write_bad) begin
									res_status_q <= dti_pkg::STAT_REJECT;
								end else begin
									res_status_q <= dti_pkg::STAT_OK;
									valid_q[req.node_index] <= 1'b1;
									if (req.node_index > node_count_q) begin
										node_count_q <= req.node_index;
									end
								end
							end
							dti_pkg::OP_LOAD: begin
								state_q <= S_RESULT;
								if (load_bad) begin
									res_status_q <= dti_pkg::STAT_BAD_FEATURE;
								end else begin
									res_status_q <= dti_pkg::STAT_OK;
									feat_q[req.feature_select] <= req.feature_value;
								end
							end
							dti_pkg::OP_PREDICT: begin
								if (node_count_q == '0 || root_q == '0) begin
									res_status_q <= dti_pkg::STAT_NO_TREE;
									state_q      <= S_RESULT;
								end else if (root_bad) begin
									res_status_q <= dti_pkg::STAT_INVALID;
									state_q      <= S_RESULT;
								end else begin
									res_status_q <= dti_pkg::STAT_OK;
									state_q      <= S_WALK;
								end
							end
							dti_pkg::OP_NONE: begin
								res_status_q <= dti_pkg::STAT_OK;
								state_q      <= S_RESULT;
							end
						endcase
					end
				end
				S_WALK: begin
					priority if (is_leaf) begin
						res_pred_q <= cur_node.value;
						state_q    <= S_RESULT;
					end else if (feat_bad) begin
						res_status_q <= dti_pkg::STAT_BAD_FEATURE;
						state_q      <= S_RESULT;
					end else if (last_level) begin
						res_status_q <= dti_pkg::STAT_DEPTH;
						state_q      <= S_RESULT;
					end else if (next_bad) begin
						res_status_q <= dti_pkg::STAT_INVALID;
						state_q      <= S_RESULT;
					end else begin
						level_q <= level_q + 1'b1;
					end
				end
				S_RESULT: begin
					if (load_rsp) begin
						rsp_pred_q   <= res_pred_q;
						rsp_status_q <= res_status_q;
						rsp_count_q  <= node_count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.prediction   = rsp_pred_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.nodes_in_use = rsp_count_q;

	// Every failed word carries a zero prediction.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != dti_pkg::STAT_OK) |-> (rsp_pred_q == '0))
		else $error("error response with nonzero prediction");

	// The node count only grows.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q >= $past(node_count_q))
		else $error("node count decreased");

	// The walk never reads more nodes than the depth limit allows.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (level_q <= dti_pkg::LAST_LEVEL))
		else $error("walk level beyond depth limit");

	// An accepted node write marks its entry valid.
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(req.node_index)])
		else $error("written node not marked valid");

	// A response word is only loaded when the register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> $stable(rsp_status_q) && $stable(rsp_count_q))
		else $error("pending response overwritten");

endmodule

`default_nettype wire

// ----- rtl/dti_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module dti_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire
